>>> hw/rtl/bdq_pkg.sv
package bdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e_t;

  // one-hot shift/insert/remove strobe shared by every cell
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } bdq_op_t;

endpackage

>>> hw/rtl/bdq_if.sv
interface bdq_cmd_if;
  import bdq_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [DATA_W-1:0] entry_value;

  modport source (output valid, command, entry_value, input ready);
  modport sink   (input valid, command, entry_value, output ready);
endinterface

interface bdq_res_if;
  import bdq_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [DATA_W-1:0] popped_value;
  logic [CNT_W-1:0]  occupancy;
  logic [CNT_W-1:0]  free_slots;

  modport source (output valid, status, popped_value, occupancy, free_slots, input ready);
  modport sink   (input valid, status, popped_value, occupancy, free_slots, output ready);
endinterface

>>> hw/rtl/bdq_cell.sv
module bdq_cell import bdq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  bdq_op_t           op,
  input  logic [DATA_W-1:0] push_data,
  input  logic [DATA_W-1:0] left_data,
  input  logic              left_valid,
  input  logic [DATA_W-1:0] right_data,
  input  logic              right_valid,
  output logic [DATA_W-1:0] data,
  output logic              valid,
  output logic [DATA_W-1:0] tap
);

  logic take_back;
  logic is_last;

  // first empty cell behind the occupied run takes a back push
  assign take_back = op.push_back && !valid && left_valid;
  assign is_last   = valid && !right_valid;
  assign tap       = is_last ? data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.push_front) begin
      valid <= left_valid;
    end else if (op.pop_front) begin
      valid <= right_valid;
    end else if (take_back) begin
      valid <= 1'b1;
    end else if (op.pop_back && is_last) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push_front) begin
      data <= left_data;
    end else if (op.pop_front) begin
      data <= right_data;
    end else if (take_back) begin
      data <= push_data;
    end
  end

endmodule

>>> hw/rtl/bounded_double_ended_queue.sv
// channel  | dir | payload                                         | transfer
// cmd      | in  | command, entry_value                            | valid && ready
// res      | out | status, popped_value, occupancy, free_slots     | valid && ready
// cfg      | in  | cfg_wr_data (capacity_limit)                    | cfg_wr_en
//
// One command per cycle while res.ready is high: the cell row and output register
// both update at the accept edge, so the result is offered in the following cycle.
// The output register holds a result until taken; a new command is taken
// in the same cycle the held result leaves.
// Reset empties the row, zeroes occupancy and sets capacity_limit to 16.
module bounded_double_ended_queue import bdq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  bdq_cmd_if.sink          cmd,
  bdq_res_if.source        res
);

  logic [CNT_W-1:0]  capacity_limit;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  free_next;
  logic              accept;
  logic              full;
  logic              empty;
  bdq_op_t           op;
  status_e_t         status_next;
  logic [DATA_W-1:0] popped_next;
  logic [DATA_W-1:0] back_data;

  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic              cell_valid [DEPTH];
  logic [DATA_W-1:0] cell_tap   [DEPTH];

  assign cmd.ready = !res.valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign limit     = (capacity_limit > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity_limit;
  assign full      = count >= limit;
  assign empty     = count == '0;

  always_comb begin
    op          = '0;
    status_next = ST_DONE;
    popped_next = '0;
    count_next  = count;
    case (cmd_e_t'(cmd.command))
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          op.push_front = accept;
          count_next    = count + CNT_W'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          op.push_back = accept;
          count_next   = count + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          op.pop_front = accept;
          popped_next  = cell_data[0];
          count_next   = count - CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          op.pop_back = accept;
          popped_next = back_data;
          count_next  = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  assign free_next = (count_next >= limit) ? '0 : limit - count_next;

  // only the last occupied cell drives a nonzero tap
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | cell_tap[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] l_data;
    logic              l_valid;
    logic [DATA_W-1:0] r_data;
    logic              r_valid;

    if (g == 0) begin : g_head
      assign l_data  = cmd.entry_value;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_data  = cell_data[g-1];
      assign l_valid = cell_valid[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_body
      assign r_data  = cell_data[g+1];
      assign r_valid = cell_valid[g+1];
    end

    bdq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .push_data   (cmd.entry_value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[g]),
      .valid       (cell_valid[g]),
      .tap         (cell_tap[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CNT_W'(16);
    end else if (cfg_wr_en) begin
      capacity_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // hold the payload until transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      res.status       <= status_next;
      res.popped_value <= popped_next;
      res.occupancy    <= count_next;
      res.free_slots   <= free_next;
    end
  end

endmodule
